// ===== rtl/core/kalman_filter_2d_random_walk_assert.svh =====
// Assertion macros used by the filter top level.
`ifndef KALMAN_FILTER_2D_RANDOM_WALK_ASSERT_SVH
`define KALMAN_FILTER_2D_RANDOM_WALK_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define KF2D_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kf2d: same-cycle check failed");

// Next-cycle implication, disabled while reset is active.
`define KF2D_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kf2d: next-cycle check failed");

`endif

// ===== rtl/core/kf2d_pkg.sv =====
// ----------------------------------------------------------------------------
// kf2d_pkg
// Types, widths and constants for the 2D random-walk Kalman filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kf2d_pkg;

  localparam int unsigned PosW    = 32;  // signed Q16.16 position
  localparam int unsigned VarW    = 31;  // unsigned Q15.16 variance
  localparam int unsigned FuncW   = 2;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned GainW   = 17;  // gain 0 .. 1.0 in Q1.16
  localparam int unsigned KDivSteps = GainW;  // one quotient bit per cycle
  localparam int unsigned MulAW   = 34;
  localparam int unsigned MulBW   = 18;
  localparam int unsigned ProdW   = MulAW + MulBW;

  localparam logic [GainW-1:0] GainOne    = 17'h10000;
  localparam logic [VarW-1:0]  VarReset   = 31'd65536;
  localparam logic [VarW-1:0]  NoiseReset = 31'd6554;

  typedef enum logic [FuncW-1:0] {
    FUNC_INIT    = 2'd0,
    FUNC_PREDICT = 2'd1,
    FUNC_UPDATE  = 2'd2
  } kf2d_func_e;

  typedef enum logic [CfgAddrW-1:0] {
    REG_PROCESS_NOISE = 2'd0,
    REG_MEAS_NOISE    = 2'd1
  } kf2d_reg_e;

  typedef enum logic [1:0] {
    MSEL_X = 2'd0,
    MSEL_Y = 2'd1,
    MSEL_P = 2'd2
  } kf2d_mul_sel_e;

  typedef struct packed {
    logic          init_est;
    logic          predict;
    logic          div_start;
    logic          mul_en;
    kf2d_mul_sel_e mul_sel;
    logic          acc_x;
    logic          acc_y;
    logic          acc_p;
    logic          load_out;
  } kf2d_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } kf2d_sts_t;

endpackage

// ===== rtl/core/kf2d_in_if.sv =====
// ----------------------------------------------------------------------------
// kf2d_in_if
// Input item channel: operation select and a 2D measurement.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kf2d_in_if;
  import kf2d_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [FuncW-1:0]       func;
  logic signed [PosW-1:0] meas_x;
  logic signed [PosW-1:0] meas_y;

  modport source (output valid, output func, output meas_x, output meas_y, input ready);
  modport sink   (input valid, input func, input meas_x, input meas_y, output ready);
endinterface

// ===== rtl/core/kf2d_out_if.sv =====
// ----------------------------------------------------------------------------
// kf2d_out_if
// Result item channel: estimate and shared variance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kf2d_out_if;
  import kf2d_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PosW-1:0] est_x;
  logic signed [PosW-1:0] est_y;
  logic [VarW-1:0]        variance;

  modport source (output valid, output est_x, output est_y, output variance, input ready);
  modport sink   (input valid, input est_x, input est_y, input variance, output ready);
endinterface

// ===== rtl/core/kf2d_cfg_if.sv =====
// ----------------------------------------------------------------------------
// kf2d_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kf2d_cfg_if;
  import kf2d_pkg::*;

  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

// ===== rtl/core/kf2d_div.sv =====
// ----------------------------------------------------------------------------
// kf2d_div
// Restoring divider for the gain: k = floor(p * 2^16 / den), one bit a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kf2d_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [kf2d_pkg::VarW-1:0] num_i,
  input  logic [kf2d_pkg::VarW:0]   den_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [kf2d_pkg::GainW-1:0] gain_o
);
  import kf2d_pkg::*;

  localparam int unsigned CntW = $clog2(KDivSteps + 1);
  localparam int unsigned RemW = VarW + 3;

  logic [RemW-1:0]   rem_q;
  logic [VarW:0]     den_q;
  logic              zero_q;
  logic [GainW-1:0]  quo_q;
  logic [CntW-1:0]   cnt_q;

  logic [RemW-1:0]   den_ext;
  logic [RemW-1:0]   rem_sub;
  logic              ge;
  logic [RemW-1:0]   rem_step;

  assign den_ext  = {2'b00, den_q};
  assign ge       = rem_q >= den_ext;
  assign rem_sub  = rem_q - den_ext;
  assign rem_step = ge ? {rem_sub[RemW-2:0], 1'b0} : {rem_q[RemW-2:0], 1'b0};

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= {3'b000, num_i};
      den_q  <= den_i;
      zero_q <= (den_i == '0);
      quo_q  <= '0;
    end else if (cnt_q != '0) begin
      rem_q <= rem_step;
      quo_q <= {quo_q[GainW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(KDivSteps);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CntW'(1);
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = (cnt_q == CntW'(1));
  // p + r of zero means p is zero too: gain is zero.
  assign gain_o = zero_q ? '0 : quo_q;

endmodule

// ===== rtl/core/kf2d_dp.sv =====
// ----------------------------------------------------------------------------
// kf2d_dp
// Filter datapath: state, noise registers, shared multiplier, output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kf2d_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kf2d_pkg::kf2d_cmd_t            cmd_i,
  output kf2d_pkg::kf2d_sts_t            sts_o,
  input  logic                           in_fire_i,
  input  logic signed [kf2d_pkg::PosW-1:0] meas_x_i,
  input  logic signed [kf2d_pkg::PosW-1:0] meas_y_i,
  input  logic                           cfg_fire_i,
  input  logic [kf2d_pkg::CfgAddrW-1:0]  cfg_addr_i,
  input  logic [kf2d_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic signed [kf2d_pkg::PosW-1:0] est_x_o,
  output logic signed [kf2d_pkg::PosW-1:0] est_y_o,
  output logic [kf2d_pkg::VarW-1:0]      variance_o
);
  import kf2d_pkg::*;

  logic [VarW-1:0]        pn_q, rn_q, p_q;
  logic signed [PosW-1:0] est_x_q, est_y_q;
  logic signed [PosW-1:0] meas_x_q, meas_y_q;
  logic signed [ProdW-1:0] prod_q;
  logic signed [PosW-1:0] out_x_q, out_y_q;
  logic [VarW-1:0]        out_p_q;

  logic [VarW:0]          pred_sum;
  logic [VarW-1:0]        pred_p;
  logic [VarW:0]          den;
  logic [GainW-1:0]       gain;
  logic signed [PosW:0]   diff_x, diff_y;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;

  assign pred_sum = {1'b0, p_q} + {1'b0, pn_q};
  assign pred_p   = pred_sum[VarW] ? '1 : pred_sum[VarW-1:0];
  assign den      = {1'b0, p_q} + {1'b0, rn_q};

  kf2d_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (p_q),
    .den_i   (den),
    .busy_o  (sts_o.div_busy),
    .done_o  (sts_o.div_done),
    .gain_o  (gain)
  );

  // 33-bit exact innovation per axis
  assign diff_x = {meas_x_q[PosW-1], meas_x_q} - {est_x_q[PosW-1], est_x_q};
  assign diff_y = {meas_y_q[PosW-1], meas_y_q} - {est_y_q[PosW-1], est_y_q};

  always_comb begin
    case (cmd_i.mul_sel)
      MSEL_X: begin
        mul_a = {diff_x[PosW], diff_x};
        mul_b = {1'b0, gain};
      end
      MSEL_Y: begin
        mul_a = {diff_y[PosW], diff_y};
        mul_b = {1'b0, gain};
      end
      MSEL_P: begin
        mul_a = {3'b000, p_q};
        mul_b = {1'b0, GainOne - gain};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      meas_x_q <= meas_x_i;
      meas_y_q <= meas_y_i;
    end
    if (cmd_i.mul_en) begin
      prod_q <= mul_p;
    end
    if (cmd_i.load_out) begin
      out_x_q <= est_x_q;
      out_y_q <= est_y_q;
      out_p_q <= p_q;
    end
  end

  // Filter state and noise registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pn_q    <= NoiseReset;
      rn_q    <= NoiseReset;
      est_x_q <= '0;
      est_y_q <= '0;
      p_q     <= VarReset;
    end else begin
      if (cfg_fire_i) begin
        case (cfg_addr_i)
          REG_PROCESS_NOISE: pn_q <= cfg_data_i[VarW-1:0];
          REG_MEAS_NOISE:    rn_q <= cfg_data_i[VarW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.init_est) begin
        est_x_q <= meas_x_q;
        est_y_q <= meas_y_q;
      end
      if (cmd_i.predict) begin
        p_q <= pred_p;
      end
      // floor(prod / 2^16); result lies between est and meas
      if (cmd_i.acc_x) begin
        est_x_q <= est_x_q + prod_q[PosW+15:16];
      end
      if (cmd_i.acc_y) begin
        est_y_q <= est_y_q + prod_q[PosW+15:16];
      end
      if (cmd_i.acc_p) begin
        p_q <= prod_q[VarW+15:16];
      end
    end
  end

  assign est_x_o    = out_x_q;
  assign est_y_o    = out_y_q;
  assign variance_o = out_p_q;

endmodule

// ===== rtl/core/kf2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// kf2d_ctrl
// Operation sequencer: issues datapath commands and owns the handshakes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kf2d_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [kf2d_pkg::FuncW-1:0]   in_func_i,
  output logic                         in_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output kf2d_pkg::kf2d_cmd_t          cmd_o,
  input  kf2d_pkg::kf2d_sts_t          sts_i
);
  import kf2d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_MX,
    S_MY,
    S_MP,
    S_LAST,
    S_DONE
  } state_e;

  state_e    state_q;
  kf2d_cmd_t cmd_q;
  kf2d_cmd_t cmd_d;
  logic      out_valid_q;
  logic      load_out;

  assign in_ready_o = (state_q == S_IDLE);
  // Result register is free, or its item leaves this cycle.
  assign load_out   = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  // Command for the next cycle
  always_comb begin
    cmd_d = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_func_i)
            FUNC_INIT:    cmd_d.init_est  = 1'b1;
            FUNC_PREDICT: cmd_d.predict   = 1'b1;
            FUNC_UPDATE:  cmd_d.div_start = 1'b1;
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (sts_i.div_done) begin
          cmd_d.mul_en  = 1'b1;
          cmd_d.mul_sel = MSEL_X;
        end
      end
      S_MX: begin
        cmd_d.acc_x   = 1'b1;
        cmd_d.mul_en  = 1'b1;
        cmd_d.mul_sel = MSEL_Y;
      end
      S_MY: begin
        cmd_d.acc_y   = 1'b1;
        cmd_d.mul_en  = 1'b1;
        cmd_d.mul_sel = MSEL_P;
      end
      S_MP: begin
        cmd_d.acc_p = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cmd_q <= cmd_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            case (in_func_i)
              FUNC_INIT:    state_q <= S_LAST;
              FUNC_PREDICT: state_q <= S_LAST;
              FUNC_UPDATE:  state_q <= S_DIV;
              default:      state_q <= S_DONE;
            endcase
          end
        end
        S_DIV: begin
          if (sts_i.div_done) begin
            state_q <= S_MX;
          end
        end
        S_MX: begin
          state_q <= S_MY;
        end
        S_MY: begin
          state_q <= S_MP;
        end
        S_MP: begin
          state_q <= S_LAST;
        end
        S_LAST: begin
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (load_out) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o          = cmd_q;
    cmd_o.load_out = load_out;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/core/kalman_filter_2d_random_walk.sv =====
// ----------------------------------------------------------------------------
// kalman_filter_2d_random_walk
// Two-axis random-walk Kalman filter in signed Q16.16, shared scalar variance.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   : one item per operation (func, meas_x, meas_y). func selects
//            init (load estimate), predict (variance += process noise,
//            saturating) or update (blend measurement with gain p/(p+r)).
//            func 3 leaves state alone and just reports it.
//   out_o  : exactly one item per input item: est_x, est_y, variance.
//   cfg_i  : register writes (0 process noise, 1 measurement noise), always
//            ready; write only while no item is in flight.
// Sequence: init and predict apply their command, then load the result;
//   func 3 goes straight to loading the result. update runs the 17-step
//   bit-serial gain divider, then three passes through the single 34x18
//   multiplier (x, y, variance) before its result is loaded.
// One item is worked on at a time; in_i.ready is high only while idle.
// A finished result sits in an output register, so the next item is taken
// while it waits; if the receiver still stalls when that next item is done,
// the block holds it until the register drains.
// Reset: estimates 0, variance 1.0, both noise registers 0.1 (6554).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "kalman_filter_2d_random_walk_assert.svh"

module kalman_filter_2d_random_walk (
  input  logic       clk_i,
  input  logic       rst_ni,
  kf2d_in_if.sink    in_i,
  kf2d_out_if.source out_o,
  kf2d_cfg_if.sink   cfg_i
);
  import kf2d_pkg::*;

  kf2d_cmd_t cmd;
  kf2d_sts_t sts;
  logic      in_fire;
  logic      cfg_fire;

  assign cfg_i.ready = 1'b1;
  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;

  // Sequencer: handshakes and the per-operation command schedule
  kf2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_func_i   (in_i.func),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Datapath: filter state, gain divider, shared multiplier, result register
  kf2d_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_fire_i  (in_fire),
    .meas_x_i   (in_i.meas_x),
    .meas_y_i   (in_i.meas_y),
    .cfg_fire_i (cfg_fire),
    .cfg_addr_i (cfg_i.addr),
    .cfg_data_i (cfg_i.data),
    .est_x_o    (out_o.est_x),
    .est_y_o    (out_o.est_y),
    .variance_o (out_o.variance)
  );

  // One item in flight: no second accept right behind the first.
  `KF2D_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_fire, !in_i.ready)
  // A divider start is always followed by a running divider.
  `KF2D_ASSERT_NEXT(a_div_runs, clk_i, rst_ni, cmd.div_start, sts.div_busy)
  // The multiplier is only used once the gain has settled.
  `KF2D_ASSERT_NOW(a_mul_after_div, clk_i, rst_ni, cmd.mul_en, !sts.div_busy)

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 2D random-walk Kalman filter. A directed table
// covers the selector values, coordinate extremes, noise register edge values,
// variance saturation and the zero-denominator update. Random target tracks
// follow it: init, then predicts and noisy measurement updates. Results are
// checked against a fixed-point bench model or hand-written expectations.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import kf2d_pkg::*;

  // Selector value and register indexes that the block ignores.
  localparam logic [FuncW-1:0]    FUNC_SPARE  = 2'd3;
  localparam logic [CfgAddrW-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CfgAddrW-1:0] REG_SPARE_B = 2'd3;

  localparam longint GainUnity   = 65536;
  localparam longint VarCeiling  = 64'h7FFF_FFFF;

  localparam int ItemsPerPhase = 190;
  localparam int HoldCycles    = 300;   // long receiver hold-off
  localparam int SettleCycles  = 30;    // idle margin before the verdict
  localparam int StallLimit    = 2000;  // cycles with no handshake at all

  // One result item: estimate and shared variance.
  typedef struct packed {
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic [VarW-1:0]        v;
  } estimate_t;

  // Directed stimulus row: either an item or a register write.
  // For a register write, code is the index and a the data.
  typedef struct packed {
    bit                  is_reg;
    logic [1:0]          code;
    logic [PosW-1:0]     a;
    logic [PosW-1:0]     b;
    bit                  typed;  // res holds a hand-written expectation
    estimate_t           res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  kf2d_in_if  in_if ();
  kf2d_out_if out_if ();
  kf2d_cfg_if cfg_if ();

  kalman_filter_2d_random_walk dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Filter model state. Written only by the stimulus process, at the edge
  // where the item or the register write is accepted.
  // --------------------------------------------------------------------------
  logic signed [PosW-1:0] m_x, m_y;
  logic [VarW-1:0]        m_var;
  logic [VarW-1:0]        m_pn, m_mn;

  estimate_t pending[$];   // expected estimates, oldest first
  row_t      plan[$];
  int        errors = 0;
  int        tx_gap_pct = 0;   // sender idle chance per cycle
  int        rx_stall_pct = 0; // receiver stall chance per cycle
  bit        hold_req = 1'b0;  // asks the receiver for a long hold-off

  // est + floor(k * (meas - est) / 2^16), difference taken at full width
  function automatic logic signed [PosW-1:0] blend(input logic signed [PosW-1:0] e,
                                                   input logic signed [PosW-1:0] m,
                                                   input longint g);
    longint d;
    d = longint'(m) - longint'(e);
    return PosW'(longint'(e) + ((d * g) >>> 16));
  endfunction

  task automatic filter_step(input logic [FuncW-1:0] f, input logic signed [PosW-1:0] mx,
                             input logic signed [PosW-1:0] my, output estimate_t r);
    longint p, den, gain, sum;
    p = m_var;
    if (f == FUNC_INIT) begin
      m_x = mx;
      m_y = my;
    end else if (f == FUNC_PREDICT) begin
      sum = p + longint'(m_pn);
      m_var = (sum > VarCeiling) ? VarCeiling[VarW-1:0] : sum[VarW-1:0];
    end else if (f == FUNC_UPDATE) begin
      den = p + longint'(m_mn);
      // zero variance and zero noise: no gain, nothing moves
      gain = (den != 0) ? (p <<< 16) / den : 0;
      if (gain > GainUnity) gain = GainUnity;
      m_x = blend(m_x, mx, gain);
      m_y = blend(m_y, my, gain);
      m_var = VarW'(((GainUnity - gain) * p) >>> 16);
    end
    // spare selector: state untouched, just reported
    r.x = m_x;
    r.y = m_y;
    r.v = m_var;
  endtask

  // --------------------------------------------------------------------------
  // Drivers. Valid is only lowered where the sender idles or a phase ends,
  // so a valid that stays high never gets two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [FuncW-1:0] f, input logic [PosW-1:0] x,
                           input logic [PosW-1:0] y);
    estimate_t r;
    cfg_if.valid <= 1'b0;
    if (tx_gap_pct != 0 && $urandom_range(99) < tx_gap_pct) begin
      in_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_gap_pct);
    end
    in_if.valid  <= 1'b1;
    in_if.func   <= f;
    in_if.meas_x <= x;
    in_if.meas_y <= y;
    do @(posedge clk_i); while (!in_if.ready);
    filter_step(f, x, y, r);
    pending = {pending, r};
  endtask

  // Registers change only with nothing in flight: every result back first.
  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input logic [CfgDataW-1:0] val);
    in_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    if (idx == REG_PROCESS_NOISE) m_pn = val[VarW-1:0];
    else if (idx == REG_MEAS_NOISE) m_mn = val[VarW-1:0];
  endtask

  // Appends one row to the directed table.
  function automatic void add_row(input row_t r);
    plan = {plan, r};
  endfunction

  function automatic row_t item_row(input logic [FuncW-1:0] f, input logic [PosW-1:0] a,
                                    input logic [PosW-1:0] b);
    row_t r;
    r = '0;
    r.code = f;
    r.a = a;
    r.b = b;
    return r;
  endfunction

  function automatic row_t checked_row(input logic [FuncW-1:0] f, input logic [PosW-1:0] a,
                                       input logic [PosW-1:0] b, input logic [PosW-1:0] ex,
                                       input logic [PosW-1:0] ey, input logic [VarW-1:0] ev);
    row_t r;
    r = item_row(f, a, b);
    r.typed = 1'b1;
    r.res.x = ex;
    r.res.y = ey;
    r.res.v = ev;
    return r;
  endfunction

  function automatic row_t reg_row(input logic [CfgAddrW-1:0] idx,
                                   input logic [CfgDataW-1:0] val);
    row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.code = idx;
    r.a = val;
    return r;
  endfunction

  // Coordinate near a center; one in eight is anywhere in the full range.
  function automatic logic [PosW-1:0] near(input logic [PosW-1:0] c,
                                           input int unsigned spread);
    if ($urandom_range(7) == 0) return $urandom;
    return c + $urandom_range(2 * spread) - spread;
  endfunction

  // Random target tracks: init, then predicts while the target wanders and
  // updates from noisy measurements of it. About one in ten outer picks is a
  // lone item with any selector and raw coordinates.
  task automatic track_phase(input int n, input bit with_hold);
    int sent, len, j, pick;
    bit held;
    logic [PosW-1:0] tx, ty;
    sent = 0;
    held = 1'b0;
    while (sent < n) begin
      if (with_hold && !held && sent >= n / 2) begin
        hold_req = 1'b1;
        held = 1'b1;
      end
      if ($urandom_range(9) == 0) begin
        send_item($urandom_range(3), $urandom, $urandom);
        sent++;
      end else begin
        tx = near(32'd0, 32'h0100_0000);
        ty = near(32'd0, 32'h0100_0000);
        send_item(FUNC_INIT, tx, ty);
        sent++;
        len = $urandom_range(4, 24);
        for (j = 0; j < len && sent < n; j++) begin
          pick = $urandom_range(19);
          if (pick == 0) begin
            send_item(FUNC_SPARE, $urandom, $urandom);
          end else if (pick < 8) begin
            tx = tx + $urandom_range(32'h0002_0000) - 32'h0001_0000;
            ty = ty + $urandom_range(32'h0002_0000) - 32'h0001_0000;
            send_item(FUNC_PREDICT, $urandom, $urandom);
          end else begin
            send_item(FUNC_UPDATE, near(tx, 32'h0004_0000), near(ty, 32'h0004_0000));
          end
          sent++;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off on request so the output
  // register fills, the next item completes behind it and in_i stalls.
  // --------------------------------------------------------------------------
  initial begin : receiver
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_if.ready <= (rx_stall_pct == 0) || ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each accepted result against the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_check
    estimate_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending.size() == 0) begin
        $display("%0t: result with none expected: x %h y %h var %h", $time,
                 out_if.est_x, out_if.est_y, out_if.variance);
        errors++;
      end else begin
        want = pending.pop_front();
        if (out_if.est_x !== want.x) begin
          $display("%0t: est_x expected %h got %h", $time, want.x, out_if.est_x);
          errors++;
        end
        if (out_if.est_y !== want.y) begin
          $display("%0t: est_y expected %h got %h", $time, want.y, out_if.est_y);
          errors++;
        end
        if (out_if.variance !== want.v) begin
          $display("%0t: variance expected %h got %h", $time, want.v, out_if.variance);
          errors++;
        end
      end
    end
  end

  // Watchdog: ends the run after too long without any handshake.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int ph;
    logic [CfgDataW-1:0] pn_val, mn_val;

    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.func    = '0;
    in_if.meas_x  = '0;
    in_if.meas_y  = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.addr   = '0;
    cfg_if.data   = '0;
    m_x   = '0;
    m_y   = '0;
    m_var = VarReset;
    m_pn  = NoiseReset;
    m_mn  = NoiseReset;

    // Default noise 0.1 each: first predict gives 1.0 + 0.1 = 72090.
    add_row(checked_row(FUNC_SPARE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 31'd65536));
    add_row(checked_row(FUNC_PREDICT, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 31'd72090));
    add_row(checked_row(FUNC_INIT, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 32'h7FFF_FFFF, 31'd72090));
    // widest differences, both signs
    add_row(item_row(FUNC_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000));
    add_row(item_row(FUNC_UPDATE, 32'hFFFF_FFFF, 32'h0000_0001));
    add_row(reg_row(REG_MEAS_NOISE, 32'h0));
    add_row(reg_row(REG_PROCESS_NOISE, 32'h0));
    add_row(item_row(FUNC_PREDICT, 32'h0, 32'h0));
    // no measurement noise: unity gain, estimate jumps to the measurement
    add_row(checked_row(FUNC_UPDATE, 32'h1234_5678, 32'hFFFF_FFFB,
                        32'h1234_5678, 32'hFFFF_FFFB, 31'd0));
    // zero variance plus zero noise: zero denominator, nothing moves
    add_row(checked_row(FUNC_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000,
                        32'h1234_5678, 32'hFFFF_FFFB, 31'd0));
    add_row(checked_row(FUNC_SPARE, 32'h0, 32'h0,
                        32'h1234_5678, 32'hFFFF_FFFB, 31'd0));
    // bit 31 of the write data is dropped
    add_row(reg_row(REG_PROCESS_NOISE, 32'hFFFF_FFFF));
    add_row(checked_row(FUNC_PREDICT, 32'h0, 32'h0,
                        32'h1234_5678, 32'hFFFF_FFFB, 31'h7FFF_FFFF));
    // saturation
    add_row(checked_row(FUNC_PREDICT, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'h1234_5678, 32'hFFFF_FFFB, 31'h7FFF_FFFF));
    // writes to unused indexes must not touch either noise register
    add_row(reg_row(REG_SPARE_A, 32'h0000_1234));
    add_row(reg_row(REG_SPARE_B, 32'h0000_1234));
    add_row(checked_row(FUNC_UPDATE, 32'h0, 32'h0, 0, 0, 31'd0));
    add_row(checked_row(FUNC_PREDICT, 32'h0, 32'h0, 0, 0, 31'h7FFF_FFFF));
    add_row(reg_row(REG_MEAS_NOISE, 32'h7FFF_FFFF));
    add_row(reg_row(REG_PROCESS_NOISE, 32'h0001_0000));
    add_row(checked_row(FUNC_PREDICT, 32'h0, 32'h0, 0, 0, 31'h7FFF_FFFF));
    // both at max: gain one half
    add_row(item_row(FUNC_UPDATE, 32'h7FFF_FFFF, 32'h8000_0000));
    add_row(item_row(FUNC_INIT, 32'h0000_0001, 32'hFFFF_FFFF));
    add_row(item_row(FUNC_UPDATE, 32'h8000_0000, 32'h7FFF_FFFF));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    tx_gap_pct   = 15;
    rx_stall_pct = 48;
    foreach (plan[i]) begin
      if (plan[i].is_reg) begin
        write_reg(plan[i].code, plan[i].a);
      end else begin
        send_item(plan[i].code, plan[i].a, plan[i].b);
        if (plan[i].typed) pending[pending.size() - 1] = plan[i].res;
      end
    end

    // Random phases: sender-light idling, then receiver-light, then none.
    for (ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          tx_gap_pct   = 15;
          rx_stall_pct = 48;
        end
        1: begin
          tx_gap_pct   = 48;
          rx_stall_pct = 15;
        end
        default: begin
          tx_gap_pct   = 0;
          rx_stall_pct = 0;
        end
      endcase
      case (ph)
        0: begin
          pn_val = 32'd6554;
          mn_val = 32'd6554;
        end
        1: begin
          pn_val = $urandom_range(32'h0010_0000);
          mn_val = $urandom_range(32'h0010_0000);
        end
        2: begin
          pn_val = 32'h7FFF_FFFF;
          mn_val = 32'h1;
        end
        3: begin
          pn_val = 32'h0;
          mn_val = 32'h7FFF_FFFF;
        end
        4: begin
          pn_val = $urandom_range(32'h0001_0000);
          mn_val = $urandom;
        end
        default: begin
          pn_val = $urandom;
          mn_val = $urandom_range(32'h0004_0000);
        end
      endcase
      write_reg(REG_PROCESS_NOISE, pn_val);
      write_reg(REG_MEAS_NOISE, mn_val);
      track_phase(ItemsPerPhase, ph == 0);
    end

    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
